@@ design/uvsv_pkg.sv @@
// ----------------------------------------------------------------------------
// UV sphere vertex generator package
// Shared constants, CORDIC angle table and register map codes.
// ----------------------------------------------------------------------------
package uvsv_pkg;

    // default parameter values
    localparam int GRID_MAX_DEF     = 1024;
    localparam int CORDIC_STEPS_DEF = 16;

    // length of the arctangent table, and so the most CORDIC iterations
    localparam int ATAN_LEN = 24;

    // CORDIC datapath: 30 fraction bits, angle in 2^-32 turn
    localparam int CW = 34;
    typedef logic signed [CW-1:0] t_cord;

    // start value of x: the gain for an unbounded number of iterations
    localparam t_cord CORDIC_GAIN = 34'sd652032874;

    localparam t_cord ATAN_TURNS [ATAN_LEN] = '{
        34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
        34'sd42667331,  34'sd21354465,  34'sd10679838,  34'sd5340245,
        34'sd2670163,   34'sd1335087,   34'sd667544,    34'sd333772,
        34'sd166886,    34'sd83443,     34'sd41722,     34'sd20861,
        34'sd10430,     34'sd5215,      34'sd2608,      34'sd1304,
        34'sd652,       34'sd326,       34'sd163,       34'sd81
    };

    // 1.0 in Q0.16 held on 17 bits
    localparam logic [16:0] ONE_Q16 = 17'd65536;

    // configuration port
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    typedef enum logic [2:0] {
        REG_RING_COUNT    = 3'd0,
        REG_SEGMENT_COUNT = 3'd1,
        REG_SPHERE_RADIUS = 3'd2,
        REG_RING_STEP     = 3'd3,
        REG_SEGMENT_STEP  = 3'd4
    } t_reg_idx;

    // register reset values
    localparam logic [10:0] RST_RING_COUNT    = 11'd16;
    localparam logic [10:0] RST_SEGMENT_COUNT = 11'd16;
    localparam logic [15:0] RST_SPHERE_RADIUS = 16'd256;
    localparam logic [15:0] RST_RING_STEP     = 16'd4369;
    localparam logic [15:0] RST_SEGMENT_STEP  = 16'd4369;

endpackage

@@ design/uvsv_req_if.sv @@
// ----------------------------------------------------------------------------
// UV sphere vertex request channel
// One word names a grid point: ring index and segment index.
// ----------------------------------------------------------------------------
interface uvsv_req_if;
    logic       valid;
    logic       ready;
    logic [9:0] ring_index;
    logic [9:0] segment_index;

    modport source (output valid, ring_index, segment_index, input ready);
    modport sink   (input valid, ring_index, segment_index, output ready);
endinterface

@@ design/uvsv_vtx_if.sv @@
// ----------------------------------------------------------------------------
// UV sphere vertex result channel
// One word carries position, normal, texture coordinate and colour.
// ----------------------------------------------------------------------------
interface uvsv_vtx_if;
    logic               valid;
    logic               ready;
    logic signed [16:0] pos_x;
    logic signed [16:0] pos_y;
    logic signed [16:0] pos_z;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic [15:0]        tex_u;
    logic [15:0]        tex_v;
    logic [15:0]        color_r;
    logic [15:0]        color_g;
    logic [15:0]        color_b;

    modport source (output valid, pos_x, pos_y, pos_z, normal_x, normal_y, normal_z,
                    tex_u, tex_v, color_r, color_g, color_b, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, normal_x, normal_y, normal_z,
                    tex_u, tex_v, color_r, color_g, color_b, output ready);
endinterface

@@ design/uv_sphere_vertex_generator_top.sv @@
// ----------------------------------------------------------------------------
// UV sphere vertex generator
// Registers from request accept to result valid: stage 0, the CORDIC stages
// (CORDIC_STEPS capped at 24), the rounding, normal and result registers.
// Throughput: one word per cycle; one CORDIC iteration per pipeline stage.
// The whole pipeline holds while the result register waits to be taken.
// Reset (synchronous, active low) clears all valid bits and loads the
// register defaults.
// ----------------------------------------------------------------------------
module uv_sphere_vertex_generator_top #(
    parameter int GRID_MAX     = uvsv_pkg::GRID_MAX_DEF,
    parameter int CORDIC_STEPS = uvsv_pkg::CORDIC_STEPS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    uvsv_req_if.sink                    i_req,
    uvsv_vtx_if.source                  o_vtx,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [uvsv_pkg::ADDR_W-1:0] paddr,
    input  logic [uvsv_pkg::DATA_W-1:0] pwdata,
    output logic [uvsv_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);

    localparam int N  = (CORDIC_STEPS > uvsv_pkg::ATAN_LEN) ? uvsv_pkg::ATAN_LEN
                                                            : CORDIC_STEPS;
    localparam int L  = N + 4;
    localparam int LW = ($clog2(GRID_MAX + 1) > 11) ? $clog2(GRID_MAX + 1) : 11;
    localparam logic [LW-1:0] GRID_LIM = LW'(GRID_MAX);

    // round a CORDIC result to Q1.14, clamp and apply the half-turn flip
    function automatic logic signed [15:0] to_q14(input uvsv_pkg::t_cord a,
                                                  input logic flip);
        uvsv_pkg::t_cord    t;
        logic signed [15:0] c;
        t = (a + uvsv_pkg::t_cord'(32768)) >>> 16;
        if (t > uvsv_pkg::t_cord'(16384))       c = 16'sd16384;
        else if (t < -uvsv_pkg::t_cord'(16384)) c = -16'sd16384;
        else                                    c = t[15:0];
        return flip ? -c : c;
    endfunction

    // fold a phase into [-1/4, 1/4) turn
    function automatic uvsv_pkg::t_cord fold_z(input logic [31:0] ph);
        logic [31:0] p;
        p = ph;
        if (ph[31:30] == 2'd1 || ph[31:30] == 2'd2) p[31] = ~ph[31];
        return uvsv_pkg::t_cord'(signed'(p));
    endfunction

    function automatic logic fold_flip(input logic [31:0] ph);
        return (ph[31:30] == 2'd1 || ph[31:30] == 2'd2);
    endfunction

    function automatic logic [9:0] clamp_idx(input logic [9:0] idx,
                                             input logic [10:0] cnt);
        logic [LW-1:0] lim;
        lim = (LW'(cnt) > GRID_LIM) ? GRID_LIM : LW'(cnt);
        if (lim == '0) lim = LW'(1);
        return (LW'(idx) > lim - LW'(1)) ? 10'(lim - LW'(1)) : idx;
    endfunction

    function automatic logic [16:0] sat_one(input logic [25:0] p);
        return (p > 26'(uvsv_pkg::ONE_Q16)) ? uvsv_pkg::ONE_Q16 : p[16:0];
    endfunction

    function automatic logic signed [15:0] prod_q14(input logic signed [15:0] a,
                                                    input logic signed [15:0] b);
        logic signed [32:0] p;
        p = ((33'(a) * 33'(b)) + 33'sd8192) >>> 14;
        if (p > 33'sd16384)       return 16'sd16384;
        else if (p < -33'sd16384) return -16'sd16384;
        else                      return p[15:0];
    endfunction

    function automatic logic signed [16:0] pos_of(input logic signed [15:0] n,
                                                  input logic [15:0] rad);
        logic signed [33:0] p;
        p = (34'(n) * 34'(signed'({1'b0, rad}))) + 34'sd8192;
        return p[30:14];
    endfunction

    function automatic logic [15:0] color_of(input logic signed [15:0] n);
        logic signed [17:0] c;
        c = (18'(n) <<< 1) + 18'sd32768;
        if (c < 18'sd0)          return 16'd0;
        else if (c > 18'sd65535) return 16'hFFFF;
        else                     return c[15:0];
    endfunction

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [10:0] r_ring_count;
    logic [10:0] r_segment_count;
    logic [15:0] r_sphere_radius;
    logic [15:0] r_ring_step;
    logic [15:0] r_segment_step;
    logic        w_cfg_wr;
    logic [2:0]  w_cfg_idx;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite;
    assign w_cfg_idx = paddr[4:2];

    // write a register on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_count    <= uvsv_pkg::RST_RING_COUNT;
            r_segment_count <= uvsv_pkg::RST_SEGMENT_COUNT;
            r_sphere_radius <= uvsv_pkg::RST_SPHERE_RADIUS;
            r_ring_step     <= uvsv_pkg::RST_RING_STEP;
            r_segment_step  <= uvsv_pkg::RST_SEGMENT_STEP;
        end else if (w_cfg_wr) begin
            case (w_cfg_idx)
                uvsv_pkg::REG_RING_COUNT:    r_ring_count    <= pwdata[10:0];
                uvsv_pkg::REG_SEGMENT_COUNT: r_segment_count <= pwdata[10:0];
                uvsv_pkg::REG_SPHERE_RADIUS: r_sphere_radius <= pwdata[15:0];
                uvsv_pkg::REG_RING_STEP:     r_ring_step     <= pwdata[15:0];
                uvsv_pkg::REG_SEGMENT_STEP:  r_segment_step  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        case (w_cfg_idx)
            uvsv_pkg::REG_RING_COUNT:    prdata = 32'(r_ring_count);
            uvsv_pkg::REG_SEGMENT_COUNT: prdata = 32'(r_segment_count);
            uvsv_pkg::REG_SPHERE_RADIUS: prdata = 32'(r_sphere_radius);
            uvsv_pkg::REG_RING_STEP:     prdata = 32'(r_ring_step);
            uvsv_pkg::REG_SEGMENT_STEP:  prdata = 32'(r_segment_step);
            default:                     prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // pipeline control: every stage advances together
    // ------------------------------------------------------------------
    logic [L-1:0] r_vld;
    logic         w_adv;

    assign w_adv       = !r_vld[L-1] || o_vtx.ready;
    // take no request while reset is held
    assign i_req.ready = i_rst_n && w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[L-2:0], i_req.valid};
        end
    end

    // ------------------------------------------------------------------
    // stage 0: clamp indices, scale to u and v, fold the phases
    // ------------------------------------------------------------------
    logic [9:0]  w_ri;
    logic [9:0]  w_si;
    logic [16:0] w_v;
    logic [16:0] w_u;
    logic [31:0] w_ph_u;
    logic [31:0] w_ph_v;

    assign w_ri   = clamp_idx(i_req.ring_index, r_ring_count);
    assign w_si   = clamp_idx(i_req.segment_index, r_segment_count);
    assign w_v    = sat_one(26'(w_ri) * 26'(r_ring_step));
    assign w_u    = uvsv_pkg::ONE_Q16 - sat_one(26'(w_si) * 26'(r_segment_step));
    assign w_ph_u = {w_u[15:0], 16'd0};
    assign w_ph_v = {w_v, 15'd0};

    uvsv_pkg::t_cord r_xu [N+1];
    uvsv_pkg::t_cord r_yu [N+1];
    uvsv_pkg::t_cord r_zu [N+1];
    uvsv_pkg::t_cord r_xv [N+1];
    uvsv_pkg::t_cord r_yv [N+1];
    uvsv_pkg::t_cord r_zv [N+1];
    logic            r_fu [N+1];
    logic            r_fv [N+1];
    logic [16:0]     r_u  [N+1];
    logic [16:0]     r_v  [N+1];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_xu[0] <= uvsv_pkg::CORDIC_GAIN;
            r_yu[0] <= '0;
            r_zu[0] <= fold_z(w_ph_u);
            r_fu[0] <= fold_flip(w_ph_u);
            r_xv[0] <= uvsv_pkg::CORDIC_GAIN;
            r_yv[0] <= '0;
            r_zv[0] <= fold_z(w_ph_v);
            r_fv[0] <= fold_flip(w_ph_v);
            r_u[0]  <= w_u;
            r_v[0]  <= w_v;
        end
    end

    // ------------------------------------------------------------------
    // CORDIC: one rotation per stage for both angles
    // ------------------------------------------------------------------
    for (genvar i = 0; i < N; i++) begin : g_cordic
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                if (r_zu[i] >= 0) begin
                    r_xu[i+1] <= r_xu[i] - (r_yu[i] >>> i);
                    r_yu[i+1] <= r_yu[i] + (r_xu[i] >>> i);
                    r_zu[i+1] <= r_zu[i] - uvsv_pkg::ATAN_TURNS[i];
                end else begin
                    r_xu[i+1] <= r_xu[i] + (r_yu[i] >>> i);
                    r_yu[i+1] <= r_yu[i] - (r_xu[i] >>> i);
                    r_zu[i+1] <= r_zu[i] + uvsv_pkg::ATAN_TURNS[i];
                end
                if (r_zv[i] >= 0) begin
                    r_xv[i+1] <= r_xv[i] - (r_yv[i] >>> i);
                    r_yv[i+1] <= r_yv[i] + (r_xv[i] >>> i);
                    r_zv[i+1] <= r_zv[i] - uvsv_pkg::ATAN_TURNS[i];
                end else begin
                    r_xv[i+1] <= r_xv[i] + (r_yv[i] >>> i);
                    r_yv[i+1] <= r_yv[i] - (r_xv[i] >>> i);
                    r_zv[i+1] <= r_zv[i] + uvsv_pkg::ATAN_TURNS[i];
                end
                r_fu[i+1] <= r_fu[i];
                r_fv[i+1] <= r_fv[i];
                r_u[i+1]  <= r_u[i];
                r_v[i+1]  <= r_v[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // round sines and cosines to Q1.14
    // ------------------------------------------------------------------
    logic signed [15:0] r_su;
    logic signed [15:0] r_cu;
    logic signed [15:0] r_sv;
    logic signed [15:0] r_cv;
    logic [16:0]        r_u_r;
    logic [16:0]        r_v_r;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_cu  <= to_q14(r_xu[N], r_fu[N]);
            r_su  <= to_q14(r_yu[N], r_fu[N]);
            r_cv  <= to_q14(r_xv[N], r_fv[N]);
            r_sv  <= to_q14(r_yv[N], r_fv[N]);
            r_u_r <= r_u[N];
            r_v_r <= r_v[N];
        end
    end

    // ------------------------------------------------------------------
    // form the normal
    // ------------------------------------------------------------------
    logic signed [15:0] r_nx;
    logic signed [15:0] r_ny;
    logic signed [15:0] r_nz;
    logic [15:0]        r_tu;
    logic [15:0]        r_tv;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_nx <= prod_q14(r_su, r_sv);
            r_nz <= prod_q14(r_cu, r_sv);
            r_ny <= -r_cv;
            r_tu <= r_u_r[16] ? 16'hFFFF : r_u_r[15:0];
            r_tv <= r_v_r[16] ? 16'hFFFF : r_v_r[15:0];
        end
    end

    // ------------------------------------------------------------------
    // result register: position, normal, texture coordinate and colour
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            o_vtx.pos_x    <= pos_of(r_nx, r_sphere_radius);
            o_vtx.pos_y    <= pos_of(r_ny, r_sphere_radius);
            o_vtx.pos_z    <= pos_of(r_nz, r_sphere_radius);
            o_vtx.normal_x <= r_nx;
            o_vtx.normal_y <= r_ny;
            o_vtx.normal_z <= r_nz;
            o_vtx.tex_u    <= r_tu;
            o_vtx.tex_v    <= r_tv;
            o_vtx.color_r  <= color_of(r_nx);
            o_vtx.color_g  <= color_of(r_ny);
            o_vtx.color_b  <= color_of(r_nz);
        end
    end

    assign o_vtx.valid = r_vld[L-1];

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    a_stall_blocks_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[L-1] && !o_vtx.ready) |-> !i_req.ready)
        else $error("request taken while result stalled");

    a_stall_keeps_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[L-1] && !o_vtx.ready) |=> r_vld[L-1])
        else $error("stalled result lost");

    a_u_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] |-> (r_u[0] <= uvsv_pkg::ONE_Q16 && r_v[0] <= uvsv_pkg::ONE_Q16))
        else $error("texture coordinate beyond one");

    a_normal_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[L-1] |-> (o_vtx.normal_x >= -16'sd16384 && o_vtx.normal_x <= 16'sd16384 &&
                        o_vtx.normal_z >= -16'sd16384 && o_vtx.normal_z <= 16'sd16384))
        else $error("normal component out of range");

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UV sphere vertex generator testbench
// Drives grid point requests under several register settings, predicts each
// vertex with a CORDIC model of its own and checks every result word field by
// field, with random idling on the request and result channels.
// ----------------------------------------------------------------------------
module tb;

    localparam int  STEPS       = (uvsv_pkg::CORDIC_STEPS_DEF > uvsv_pkg::ATAN_LEN)
                                  ? uvsv_pkg::ATAN_LEN : uvsv_pkg::CORDIC_STEPS_DEF;
    localparam int  DRAIN_CYC   = uvsv_pkg::CORDIC_STEPS_DEF + 16;
    localparam int  CYCLE_LIMIT = 500000;

    typedef struct packed {
        logic signed [16:0] pos_x;
        logic signed [16:0] pos_y;
        logic signed [16:0] pos_z;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic [15:0]        tex_u;
        logic [15:0]        tex_v;
        logic [15:0]        color_r;
        logic [15:0]        color_g;
        logic [15:0]        color_b;
    } t_vertex;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [uvsv_pkg::ADDR_W-1:0]   paddr;
    logic [uvsv_pkg::DATA_W-1:0]   pwdata;
    logic [uvsv_pkg::DATA_W-1:0]   prdata;
    logic                          pready;

    uvsv_req_if req_if ();
    uvsv_vtx_if vtx_if ();

    uv_sphere_vertex_generator_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_vtx   (vtx_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // register copies held by the predictor
    logic [10:0] ring_cnt_q;
    logic [10:0] seg_cnt_q;
    logic [15:0] radius_q;
    logic [15:0] ring_step_q;
    logic [15:0] seg_step_q;

    t_vertex     vertex_queue [$];
    int          fail_count;
    int          cycle_count;
    bit          no_idle;

    // clock
    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // watchdog
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic longint clamp_l(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // sine and cosine of a phase where 2^32 is one turn, Q1.14
    function automatic void sin_cos(input logic [31:0] phase, output longint s,
                                    output longint c);
        logic   flip;
        longint x, y, z, xs, ys;
        flip = (phase[31:30] == 2'b01) || (phase[31:30] == 2'b10);
        if (flip) begin
            phase = phase + 32'h8000_0000;
        end
        z = $signed(phase);
        x = longint'(uvsv_pkg::CORDIC_GAIN);
        y = 0;
        for (int i = 0; i < STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys; y = y + xs; z = z - longint'(uvsv_pkg::ATAN_TURNS[i]);
            end else begin
                x = x + ys; y = y - xs; z = z + longint'(uvsv_pkg::ATAN_TURNS[i]);
            end
        end
        x = clamp_l((x + 32768) >>> 16, -16384, 16384);
        y = clamp_l((y + 32768) >>> 16, -16384, 16384);
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic longint clamp_index(longint idx, longint count);
        longint lim;
        lim = (count > uvsv_pkg::GRID_MAX_DEF) ? uvsv_pkg::GRID_MAX_DEF : count;
        if (lim < 1) lim = 1;
        return (idx > lim - 1) ? lim - 1 : idx;
    endfunction

    function automatic logic [16:0] pos_of(longint n);
        longint p;
        p = (n * longint'(radius_q) + 8192) >>> 14;
        return p[16:0];
    endfunction

    function automatic logic [15:0] colour_of(longint n);
        longint c;
        c = clamp_l(2 * n + 32768, 0, 65535);
        return c[15:0];
    endfunction

    function automatic t_vertex predict_vertex(logic [9:0] ring, logic [9:0] seg);
        t_vertex     vx;
        longint      r, sg, pv, pu, su, cu, sv, cv, nx, ny, nz;
        logic [31:0] ph_u, ph_v;
        r  = clamp_index(ring, ring_cnt_q);
        sg = clamp_index(seg, seg_cnt_q);
        pv = r * ring_step_q;
        if (pv > 65536) pv = 65536;
        pu = sg * seg_step_q;
        if (pu > 65536) pu = 65536;
        pu = 65536 - pu;
        ph_u = 32'(pu << 16);
        ph_v = 32'(pv << 15);
        sin_cos(ph_u, su, cu);
        sin_cos(ph_v, sv, cv);
        nx = clamp_l((su * sv + 8192) >>> 14, -16384, 16384);
        nz = clamp_l((cu * sv + 8192) >>> 14, -16384, 16384);
        ny = -cv;
        vx.pos_x    = pos_of(nx);
        vx.pos_y    = pos_of(ny);
        vx.pos_z    = pos_of(nz);
        vx.normal_x = nx[15:0];
        vx.normal_y = ny[15:0];
        vx.normal_z = nz[15:0];
        vx.tex_u    = (pu > 65535) ? 16'hFFFF : pu[15:0];
        vx.tex_v    = (pv > 65535) ? 16'hFFFF : pv[15:0];
        vx.color_r  = colour_of(nx);
        vx.color_g  = colour_of(ny);
        vx.color_b  = colour_of(nz);
        return vx;
    endfunction

    // ------------------------------------------------------------------
    // result side: random stalls, then check each word against the oldest
    // ------------------------------------------------------------------
    int stall_left;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_left    <= 0;
            vtx_if.ready  <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left   <= stall_left - 1;
            vtx_if.ready <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 9) == 0) begin
            stall_left   <= $urandom_range(0, 18);
            vtx_if.ready <= 1'b0;
        end else begin
            vtx_if.ready <= 1'b1;
        end
    end

    task automatic check_field(string name, logic [16:0] exp_v, logic [16:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_vertex ev;
        if (i_rst_n && vtx_if.valid && vtx_if.ready) begin
            if (vertex_queue.size() == 0) begin
                $display("%0t: unexpected result word, expected none, actual pos_x %0h",
                         $time, vtx_if.pos_x);
                fail_count++;
            end else begin
                ev = vertex_queue.pop_front();
                check_field("pos_x", ev.pos_x, vtx_if.pos_x);
                check_field("pos_y", ev.pos_y, vtx_if.pos_y);
                check_field("pos_z", ev.pos_z, vtx_if.pos_z);
                check_field("normal_x", 17'(ev.normal_x), 17'(vtx_if.normal_x));
                check_field("normal_y", 17'(ev.normal_y), 17'(vtx_if.normal_y));
                check_field("normal_z", 17'(ev.normal_z), 17'(vtx_if.normal_z));
                check_field("tex_u", 17'(ev.tex_u), 17'(vtx_if.tex_u));
                check_field("tex_v", 17'(ev.tex_v), 17'(vtx_if.tex_v));
                check_field("color_r", 17'(ev.color_r), 17'(vtx_if.color_r));
                check_field("color_g", 17'(ev.color_g), 17'(vtx_if.color_g));
                check_field("color_b", 17'(ev.color_b), 17'(vtx_if.color_b));
            end
        end
    end

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------
    // send one word; valid stays high afterwards until a gap or a drain lowers it
    task automatic send_vertex(logic [9:0] ring, logic [9:0] seg);
        req_if.valid         <= 1'b1;
        req_if.ring_index    <= ring;
        req_if.segment_index <= seg;
        do @(posedge i_clk); while (!req_if.ready);
        vertex_queue.insert(vertex_queue.size(), predict_vertex(ring, seg));
    endtask

    // drop valid for a random burst now and then
    task automatic maybe_gap();
        if (!no_idle && $urandom_range(0, 7) == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
    endtask

    // hold until every expected word has come, then let the pipe settle
    task automatic drain();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        wait (vertex_queue.size() == 0);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    task automatic write_reg(int idx, logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= uvsv_pkg::ADDR_W'(4 * idx);
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            uvsv_pkg::REG_RING_COUNT:    ring_cnt_q  = value[10:0];
            uvsv_pkg::REG_SEGMENT_COUNT: seg_cnt_q   = value[10:0];
            uvsv_pkg::REG_SPHERE_RADIUS: radius_q    = value[15:0];
            uvsv_pkg::REG_RING_STEP:     ring_step_q = value[15:0];
            uvsv_pkg::REG_SEGMENT_STEP:  seg_step_q  = value[15:0];
            default: ;
        endcase
    endtask

    task automatic set_grid(logic [10:0] rc, logic [10:0] sc, logic [15:0] rad,
                            logic [15:0] rs, logic [15:0] ss);
        write_reg(uvsv_pkg::REG_RING_COUNT, 32'(rc));
        write_reg(uvsv_pkg::REG_SEGMENT_COUNT, 32'(sc));
        write_reg(uvsv_pkg::REG_SPHERE_RADIUS, 32'(rad));
        write_reg(uvsv_pkg::REG_RING_STEP, 32'(rs));
        write_reg(uvsv_pkg::REG_SEGMENT_STEP, 32'(ss));
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_reset_defaults();
        send_vertex(10'd0, 10'd0);
        send_vertex(10'd15, 10'd15);
        send_vertex(10'd8, 10'd4);
        send_vertex(10'd1023, 10'd1023);
        send_vertex(10'd4, 10'd12);
        drain();
    endtask

    task automatic test_extremes();
        // largest grid and radius, a step that saturates, and a zero radius
        set_grid(11'd1024, 11'd1024, 16'hFFFF, 16'd64, 16'd64);
        send_vertex(10'd0, 10'd1023);
        send_vertex(10'd1023, 10'd0);
        send_vertex(10'd512, 10'd256);
        send_vertex(10'd341, 10'd768);
        drain();
        set_grid(11'd2047, 11'd2047, 16'd0, 16'hFFFF, 16'hFFFF);
        send_vertex(10'd1, 10'd1);
        send_vertex(10'd1023, 10'd2);
        send_vertex(10'd0, 10'd0);
        drain();
    endtask

    task automatic test_clamp_and_zero_step();
        // counts of zero and one allow only index zero
        set_grid(11'd0, 11'd1, 16'd256, 16'd0, 16'd0);
        send_vertex(10'd5, 10'd7);
        send_vertex(10'd1023, 10'd1023);
        drain();
        // zero step with a normal grid gives u of one and v of zero
        set_grid(11'd2, 11'd2, 16'd1000, 16'd0, 16'd0);
        send_vertex(10'd1, 10'd1);
        send_vertex(10'd0, 10'd1023);
        // writes to unused addresses are ignored
        drain();
        write_reg(5, 32'hFFFF_FFFF);
        write_reg(7, 32'h0000_0000);
        set_grid(11'd2, 11'd2, 16'd512, 16'd65535, 16'd65535);
        send_vertex(10'd1, 10'd0);
        send_vertex(10'd0, 10'd1);
        send_vertex(10'd1, 10'd1);
        drain();
    endtask

    task automatic test_random_grids();
        logic [10:0] rc, sc;
        logic [15:0] rs, ss;
        logic [9:0]  ri, si;
        for (int ph = 0; ph < 11; ph++) begin
            if (ph == 10) no_idle = 1'b1;
            if ($urandom_range(0, 3) == 0) begin
                // noisy registers
                rc = 11'($urandom); sc = 11'($urandom);
                rs = 16'($urandom); ss = 16'($urandom);
            end else begin
                // well-formed grid with matching steps
                rc = (ph == 3) ? 11'd1024 : 11'($urandom_range(2, 64));
                sc = (ph == 5) ? 11'd1024 : 11'($urandom_range(2, 64));
                rs = 16'(65536 / (rc - 1));
                ss = 16'(65536 / (sc - 1));
            end
            set_grid(rc, sc, 16'($urandom), rs, ss);
            for (int k = 0; k < 48; k++) begin
                if ($urandom_range(0, 4) == 0) begin
                    ri = 10'($urandom); si = 10'($urandom);
                end else begin
                    ri = 10'($urandom_range(0, (rc > 11'd1) ? rc - 1 : 0));
                    si = 10'($urandom_range(0, (sc > 11'd1) ? sc - 1 : 0));
                end
                send_vertex(ri, si);
                maybe_gap();
            end
            drain();
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        fail_count           = 0;
        no_idle              = 1'b0;
        i_rst_n              = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        req_if.valid         = 1'b0;
        req_if.ring_index    = '0;
        req_if.segment_index = '0;
        ring_cnt_q           = uvsv_pkg::RST_RING_COUNT;
        seg_cnt_q            = uvsv_pkg::RST_SEGMENT_COUNT;
        radius_q             = uvsv_pkg::RST_SPHERE_RADIUS;
        ring_step_q          = uvsv_pkg::RST_RING_STEP;
        seg_step_q           = uvsv_pkg::RST_SEGMENT_STEP;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_extremes();
        test_clamp_and_zero_step();
        test_random_grids();

        drain();
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
